/* rtl/lzw_variable_width_decoder_defines.svh */
// Assertion macros for the LZW variable-width decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZWD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzw decoder check failed");

// Next-cycle implication, checked outside reset.
`define LZWD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzw decoder check failed");

`endif

/* rtl/lzwd_pkg.sv */
// Shared types and constants for the LZW variable-width decoder.
// No dependencies.
`timescale 1ns / 1ps

package lzwd_pkg;

	localparam logic [8:0] CLEAR_CODE = 9'd256;
	localparam logic [8:0] END_CODE   = 9'd257;
	localparam logic [8:0] FIRST_SLOT = 9'd258;
	localparam logic [3:0] MIN_WIDTH  = 4'd9;
	localparam logic [9:0] MIN_TOP    = 10'd512;

	localparam logic CMD_FEED  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [2:0] ST_RUNNING   = 3'd0;
	localparam logic [2:0] ST_END_CODE  = 3'd1;
	localparam logic [2:0] ST_BAD_CODE  = 3'd2;
	localparam logic [2:0] ST_LIMIT     = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic [12:0] pending;
		logic        refused;
		logic [2:0]  status;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN,
		S_RESP
	} seq_state_t;

endpackage

/* rtl/lzwd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lzw_variable_width_decoder.sv */
// LZW decoder, TIFF style, MSB-first codes of 9 to MAX_CODE_BITS bits.
// Uses lzwd_pkg, lzwd_ram and lzw_variable_width_decoder_defines.svh.
`timescale 1ns / 1ps
`include "lzw_variable_width_decoder_defines.svh"

// Usage:
//  in_valid/in_stall/in_data carries commands: cmd 0 feeds one compressed byte,
//  cmd 1 pops one decoded byte. Every command yields exactly one result item on
//  res_valid/res_stall/res_data (byte, byte valid, pending count, refused, status).
//  cfg_valid/cfg_ready/cfg_data writes output_limit; write only while idle.
//  Flow: a pop, a refused or ignored feed, a feed that completes no code and
//  a feed that completes a clear, end or bad code go from accept straight to the
//  result state. A feed that decodes a code into bytes walks the prefix/suffix
//  RAM at one dictionary entry per cycle, each read feeding the next address,
//  then passes the finish state before the result state. One item is in work
//  at a time; in_stall is high until its result has been loaded into the output
//  register.
//  A stalled result holds in the output register; the block accepts the next
//  command meanwhile and waits in its result state if that command finishes
//  before the register frees up.
//  Reset: dictionary cleared to 9-bit codes, no bytes pending, status running,
//  output_limit all ones. The RAMs need no clearing; unwritten entries are
//  never read.
module lzw_variable_width_decoder #(
	parameter int MAX_CODE_BITS = 12,
	parameter int COUNT_BITS    = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lzwd_pkg::in_item_t in_data,
	output logic               res_valid,
	input  logic               res_stall,
	output lzwd_pkg::out_item_t res_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        cfg_data
);

	localparam int AW    = MAX_CODE_BITS;
	localparam int SIZE  = 1 << AW;
	localparam int DW    = AW + 1;
	localparam int BUFW  = AW + 8;
	localparam int CNTW  = $clog2(AW + 8 + 1);
	localparam int CWW   = $clog2(AW + 1);
	localparam int TABW  = AW + 8;

	localparam logic [DW-1:0]         SIZE_D = DW'(SIZE);
	localparam logic [AW-1:0]         FIRST_A = AW'(lzwd_pkg::FIRST_SLOT);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	lzwd_pkg::seq_state_t state_q, state_d;

	logic [BUFW-1:0]       buf_q, buf_d;
	logic [CNTW-1:0]       cnt_q, cnt_d;
	logic [CWW-1:0]        cw_q, cw_d;
	logic [DW-1:0]         wt_q, wt_d;
	logic [DW-1:0]         ns_q, ns_d;
	logic [7:0]            fc_q, fc_d;
	logic                  fc_ok_q, fc_ok_d;
	logic [AW-1:0]         prev_q, prev_d;
	logic                  prev_ok_q, prev_ok_d;
	logic [DW-1:0]         depth_q, depth_d;
	logic [COUNT_BITS-1:0] be_q, be_d;
	logic [2:0]            fin_q, fin_d;
	logic [23:0]           limit_q;
	logic [AW-1:0]         code_q, code_d;
	logic [AW-1:0]         c_q, c_d;
	logic                  last_q, last_d;
	logic                  ov_q, ov_d;
	logic                  ref_q, ref_d;
	logic                  res_valid_q;
	lzwd_pkg::out_item_t   res_data_q;

	logic                  accept;
	logic                  go_walk, go_fin, go_resp, walk_more, res_free;

	logic                  tab_we, tab_re, stk_we, stk_re;
	logic [AW-1:0]         tab_wa, tab_ra, stk_wa, stk_ra;
	logic [TABW-1:0]       tab_wd, tab_rd;
	logic [7:0]            stk_wd, stk_rd;

	// feed path signals
	logic [BUFW-1:0]       fbuf;
	logic [CNTW-1:0]       fcnt;
	logic [CNTW-1:0]       fsh;
	logic [BUFW-1:0]       fshift;
	logic [AW-1:0]         fmask;
	logic [AW-1:0]         fcode;
	logic                  have_code;
	logic [AW-1:0]         start_code;
	logic [AW-1:0]         pfx;
	logic [7:0]            low;
	logic [DW-1:0]         ns_inc;
	logic [COUNT_BITS-1:0] be_inc;

	lzwd_ram #(.WIDTH(TABW), .DEPTH(SIZE)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd),
		.re(tab_re), .raddr(tab_ra), .rdata(tab_rd)
	);

	lzwd_ram #(.WIDTH(8), .DEPTH(SIZE)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
	);

	assign accept   = in_valid && !in_stall;
	assign res_free = !res_valid_q || !res_stall;

	// bit unpacking for a feed
	always_comb begin
		fbuf      = BUFW'({buf_q, in_data.in_byte});
		fcnt      = cnt_q + CNTW'(8);
		have_code = fcnt >= CNTW'(cw_q);
		fsh       = fcnt - CNTW'(cw_q);
		fshift    = fbuf >> fsh;
		fmask     = AW'(wt_q - DW'(1));
		fcode     = fshift[AW-1:0] & fmask;
	end

	always_comb begin
		buf_d = buf_q; cnt_d = cnt_q; cw_d = cw_q; wt_d = wt_q; ns_d = ns_q;
		fc_d = fc_q; fc_ok_d = fc_ok_q; prev_d = prev_q; prev_ok_d = prev_ok_q;
		depth_d = depth_q; be_d = be_q; fin_d = fin_q; code_d = code_q;
		c_d = c_q; last_d = last_q; ov_d = ov_q; ref_d = ref_q;
		tab_we = 1'b0; tab_wa = ns_q[AW-1:0]; tab_wd = {prev_q, code_q[7:0]};
		tab_re = 1'b0; tab_ra = code_q;
		stk_we = 1'b0; stk_wa = depth_q[AW-1:0]; stk_wd = fc_q;
		stk_re = 1'b0; stk_ra = AW'(depth_q - DW'(1));
		go_walk = 1'b0; go_fin = 1'b0; go_resp = 1'b0; walk_more = 1'b0;
		start_code = fcode;
		pfx = tab_rd[TABW-1:8];
		low = code_q[7:0];
		ns_inc = ns_q + DW'(1);
		be_inc = (be_q != CMAX) ? be_q + COUNT_BITS'(1) : be_q;

		unique case (state_q)
			lzwd_pkg::S_IDLE: begin
				if (accept) begin
					ov_d = 1'b0;
					ref_d = 1'b0;
					go_resp = 1'b1;
					if (in_data.cmd == lzwd_pkg::CMD_FEED) begin
						if (depth_q != '0) begin
							ref_d = 1'b1;
						end else if (fin_q == lzwd_pkg::ST_RUNNING) begin
							buf_d = fbuf;
							cnt_d = fcnt;
							if (have_code) begin
								cnt_d = fsh;
								buf_d = fbuf & (BUFW'((BUFW+1)'(1) << fsh) - BUFW'(1));
								c_d = fcode;
								last_d = in_data.last_byte;
								if (fcode == AW'(lzwd_pkg::END_CODE)) begin
									fin_d = lzwd_pkg::ST_END_CODE;
								end else if (fcode == AW'(lzwd_pkg::CLEAR_CODE)) begin
									cw_d = CWW'(lzwd_pkg::MIN_WIDTH);
									wt_d = DW'(lzwd_pkg::MIN_TOP);
									ns_d = DW'(lzwd_pkg::FIRST_SLOT);
									fc_d = '0; fc_ok_d = 1'b0;
									prev_d = '0; prev_ok_d = 1'b0;
									if (in_data.last_byte) begin
										fin_d = lzwd_pkg::ST_EXHAUSTED;
									end
								end else if (DW'(fcode) == ns_q && fc_ok_q) begin
									// KwKwK: first char of previous string goes first
									stk_we = 1'b1;
									depth_d = depth_q + DW'(1);
									start_code = prev_q;
									go_resp = 1'b0;
								end else if (DW'(fcode) >= ns_q) begin
									fin_d = lzwd_pkg::ST_BAD_CODE;
								end else begin
									go_resp = 1'b0;
								end
								if (!go_resp) begin
									code_d = start_code;
									if (start_code >= FIRST_A) begin
										tab_re = 1'b1;
										tab_ra = start_code;
										go_walk = 1'b1;
									end else begin
										go_fin = 1'b1;
									end
								end
							end else if (in_data.last_byte) begin
								fin_d = lzwd_pkg::ST_EXHAUSTED;
							end
						end
					end else if (depth_q != '0) begin
						stk_re = 1'b1;
						depth_d = depth_q - DW'(1);
						ov_d = 1'b1;
						be_d = be_inc;
						if (32'(be_inc) >= 32'(limit_q) || be_inc == CMAX) begin
							fin_d = lzwd_pkg::ST_LIMIT;
							depth_d = '0;
						end
					end
				end
			end
			lzwd_pkg::S_WALK: begin
				stk_we = 1'b1;
				stk_wd = tab_rd[7:0];
				depth_d = depth_q + DW'(1);
				code_d = pfx;
				if (pfx >= FIRST_A && depth_q < SIZE_D - DW'(1)) begin
					tab_re = 1'b1;
					tab_ra = pfx;
					walk_more = 1'b1;
				end
			end
			lzwd_pkg::S_FIN: begin
				if (!depth_q[AW]) begin
					stk_we = 1'b1;
					stk_wd = low;
					depth_d = depth_q + DW'(1);
				end
				fc_d = low;
				fc_ok_d = 1'b1;
				if (ns_q < wt_q && prev_ok_q) begin
					tab_we = 1'b1;
					tab_wd = {prev_q, low};
					ns_d = ns_inc;
				end
				prev_d = c_q;
				prev_ok_d = 1'b1;
				// early change: grow once slot+1 reaches the top
				if (ns_d + DW'(1) >= wt_q && cw_q < CWW'(AW)) begin
					cw_d = cw_q + CWW'(1);
					wt_d = wt_q << 1;
				end
				if (last_q) begin
					fin_d = lzwd_pkg::ST_EXHAUSTED;
				end
			end
			lzwd_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lzwd_pkg::S_IDLE: begin
				if (go_walk) state_d = lzwd_pkg::S_WALK;
				else if (go_fin) state_d = lzwd_pkg::S_FIN;
				else if (go_resp) state_d = lzwd_pkg::S_RESP;
			end
			lzwd_pkg::S_WALK: begin
				if (!walk_more) state_d = lzwd_pkg::S_FIN;
			end
			lzwd_pkg::S_FIN: state_d = lzwd_pkg::S_RESP;
			lzwd_pkg::S_RESP: begin
				if (res_free) state_d = lzwd_pkg::S_IDLE;
			end
			default: state_d = lzwd_pkg::S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q) inside
			lzwd_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			lzwd_pkg::S_WALK, lzwd_pkg::S_FIN, lzwd_pkg::S_RESP: begin
				in_stall = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwd_pkg::S_IDLE;
			buf_q <= '0; cnt_q <= '0;
			cw_q <= CWW'(lzwd_pkg::MIN_WIDTH);
			wt_q <= DW'(lzwd_pkg::MIN_TOP);
			ns_q <= DW'(lzwd_pkg::FIRST_SLOT);
			fc_q <= '0; fc_ok_q <= 1'b0;
			prev_q <= '0; prev_ok_q <= 1'b0;
			depth_q <= '0; be_q <= '0;
			fin_q <= lzwd_pkg::ST_RUNNING;
			limit_q <= 24'hFFFFFF;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			buf_q <= buf_d; cnt_q <= cnt_d; cw_q <= cw_d; wt_q <= wt_d; ns_q <= ns_d;
			fc_q <= fc_d; fc_ok_q <= fc_ok_d; prev_q <= prev_d; prev_ok_q <= prev_ok_d;
			depth_q <= depth_d; be_q <= be_d; fin_q <= fin_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (state_q == lzwd_pkg::S_RESP && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		code_q <= code_d; c_q <= c_d; last_q <= last_d; ov_q <= ov_d; ref_q <= ref_d;
		if (state_q == lzwd_pkg::S_RESP && res_free) begin
			res_data_q.out_byte  <= ov_q ? stk_rd : 8'd0;
			res_data_q.out_valid <= ov_q;
			res_data_q.pending   <= 13'(depth_q);
			res_data_q.refused   <= ref_q;
			res_data_q.status    <= fin_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	`LZWD_ASSERT_IMPL(a_depth_bound, 1'b1, depth_q <= SIZE_D)
	`LZWD_ASSERT_IMPL(a_walk_code, state_q == lzwd_pkg::S_WALK, code_q >= FIRST_A)
	`LZWD_ASSERT_IMPL(a_slot_bound, 1'b1, ns_q <= wt_q)
	`LZWD_ASSERT_NEXT(a_resp_loads, state_q == lzwd_pkg::S_RESP && res_free, res_valid_q)

endmodule
